// ===== rtl/srr_pkg.sv =====
// Shared constants, types and codes for the selective-repeat receiver.
package srr_pkg;

  // Storage and field widths
  localparam int MAX_SEQ    = 16;
  localparam int SEQ_W      = 4;
  localparam int SPACE_W    = 5;
  localparam int WIN_W      = 4;
  localparam int DATA_W     = 32;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 5;

  // Configuration limits and reset values
  localparam logic [SPACE_W-1:0] SPACE_MIN   = 5'd2;
  localparam logic [SPACE_W-1:0] SPACE_MAX   = 5'd16;
  localparam logic [SPACE_W-1:0] SPACE_RESET = 5'd8;
  localparam logic [WIN_W-1:0]   WIN_LIMIT   = 4'd8;
  localparam logic [WIN_W-1:0]   WIN_RESET   = 4'd4;

  // Register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_SEQ_SPACE   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_WINDOW_SIZE = 2'd1;

  // Result kinds
  localparam logic KIND_ACK  = 1'b0;
  localparam logic KIND_DATA = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_HEAD,
    ST_READ,
    ST_SEND,
    ST_ACK
  } srr_state_t;

  // Controller to datapath
  typedef struct packed {
    logic latch_in;
    logic store;
    logic load_head;
    logic load_data;
    logic load_ack;
    logic end_run;
  } srr_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic corrupt;
    logic in_window;
    logic at_base;
    logic run_more;
    logic out_free;
  } srr_status_t;

endpackage

// ===== rtl/srr_ctrl.sv =====
// Controller state machine for the selective-repeat receiver.
module srr_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  srr_pkg::srr_status_t status,
  output srr_pkg::srr_cmd_t    cmd
);

  srr_pkg::srr_state_t state;
  srr_pkg::srr_state_t state_next;

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= srr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Select next state
  always_comb begin
    state_next = state;
    unique case (state)
      srr_pkg::ST_IDLE: begin
        if (in_valid) state_next = srr_pkg::ST_CHECK;
      end
      srr_pkg::ST_CHECK: begin
        priority if (status.corrupt) begin
          state_next = srr_pkg::ST_IDLE;
        end else if (status.in_window && status.at_base) begin
          state_next = srr_pkg::ST_HEAD;
        end else begin
          state_next = srr_pkg::ST_ACK;
        end
      end
      srr_pkg::ST_HEAD: begin
        if (status.out_free) state_next = srr_pkg::ST_READ;
      end
      srr_pkg::ST_READ: begin
        if (status.run_more) begin
          state_next = srr_pkg::ST_SEND;
        end else begin
          state_next = srr_pkg::ST_ACK;
        end
      end
      srr_pkg::ST_SEND: begin
        if (status.out_free) state_next = srr_pkg::ST_READ;
      end
      srr_pkg::ST_ACK: begin
        if (status.out_free) state_next = srr_pkg::ST_IDLE;
      end
      default: state_next = srr_pkg::ST_IDLE;
    endcase
  end

  // Drive commands
  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    unique case (state)
      srr_pkg::ST_IDLE: begin
        in_ready     = 1'b1;
        cmd.latch_in = in_valid;
      end
      srr_pkg::ST_CHECK: begin
        cmd.store = !status.corrupt && status.in_window && !status.at_base;
      end
      srr_pkg::ST_HEAD: cmd.load_head = status.out_free;
      srr_pkg::ST_READ: cmd.end_run   = !status.run_more;
      srr_pkg::ST_SEND: cmd.load_data = status.out_free;
      srr_pkg::ST_ACK:  cmd.load_ack  = status.out_free;
      default: begin
        in_ready = 1'b0;
        cmd      = '0;
      end
    endcase
  end

endmodule

// ===== rtl/srr_dp.sv =====
// Datapath: configuration, window base, marks, held payload store and result register.
module srr_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [srr_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [srr_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic [srr_pkg::SEQ_W-1:0]           seq_num,
  input  logic                                checksum_ok,
  input  logic [srr_pkg::DATA_W-1:0]          payload,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                kind,
  output logic [srr_pkg::SEQ_W-1:0]           ack_num,
  output logic [srr_pkg::DATA_W-1:0]          data_out,
  output logic                                last,
  input  srr_pkg::srr_cmd_t                   cmd,
  output srr_pkg::srr_status_t                status
);

  logic [srr_pkg::SPACE_W-1:0] seq_space;
  logic [srr_pkg::WIN_W-1:0]   window_size;
  logic [srr_pkg::SPACE_W-1:0] space_eff;
  logic [srr_pkg::WIN_W-1:0]   win_eff;
  logic                        restart;

  logic [srr_pkg::SEQ_W-1:0]   window_base;
  logic [srr_pkg::MAX_SEQ-1:0] held_mark;
  logic [srr_pkg::DATA_W-1:0]  held_payload [srr_pkg::MAX_SEQ];
  logic [srr_pkg::DATA_W-1:0]  rd_data;

  logic [srr_pkg::SEQ_W-1:0]   seq_q;
  logic                        ok_q;
  logic [srr_pkg::DATA_W-1:0]  payload_q;

  logic [srr_pkg::SEQ_W-1:0]   cursor;
  logic [srr_pkg::SEQ_W-1:0]   cursor_next;
  logic [srr_pkg::SEQ_W-1:0]   head_next;
  logic [srr_pkg::WIN_W-1:0]   run_cnt;
  logic [srr_pkg::SPACE_W-1:0] offset;
  logic                        load_any;

  // Clamp configuration to its usable range
  always_comb begin
    priority if (seq_space < srr_pkg::SPACE_MIN) begin
      space_eff = srr_pkg::SPACE_MIN;
    end else if (seq_space > srr_pkg::SPACE_MAX) begin
      space_eff = srr_pkg::SPACE_MAX;
    end else begin
      space_eff = seq_space;
    end
  end

  always_comb begin
    win_eff = (window_size == '0) ? srr_pkg::WIN_W'(1) : window_size;
    if ({1'b0, win_eff} > space_eff) win_eff = srr_pkg::WIN_W'(space_eff);
    if (win_eff > srr_pkg::WIN_LIMIT) win_eff = srr_pkg::WIN_LIMIT;
  end

  assign restart = cfg_we && (cfg_addr == srr_pkg::REG_SEQ_SPACE ||
                              cfg_addr == srr_pkg::REG_WINDOW_SIZE);

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      seq_space   <= srr_pkg::SPACE_RESET;
      window_size <= srr_pkg::WIN_RESET;
    end else if (cfg_we) begin
      if (cfg_addr == srr_pkg::REG_SEQ_SPACE) seq_space <= cfg_wdata;
      if (cfg_addr == srr_pkg::REG_WINDOW_SIZE) begin
        window_size <= cfg_wdata[srr_pkg::WIN_W-1:0];
      end
    end
  end

  // Capture the accepted request
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      seq_q     <= seq_num;
      ok_q      <= checksum_ok;
      payload_q <= payload;
    end
  end

  // Classify the request against the circular window
  always_comb begin
    if (seq_q >= window_base) begin
      offset = {1'b0, seq_q} - {1'b0, window_base};
    end else begin
      offset = {1'b0, seq_q} + space_eff - {1'b0, window_base};
    end
  end

  // Advance a position with wrap at the sequence space
  always_comb begin
    head_next   = ({1'b0, window_base} + 5'd1 == space_eff) ? '0 : window_base + 4'd1;
    cursor_next = ({1'b0, cursor} + 5'd1 == space_eff) ? '0 : cursor + 4'd1;
  end

  assign load_any = cmd.load_head || cmd.load_data || cmd.load_ack;

  always_comb begin
    status.corrupt   = !ok_q;
    status.in_window = ({1'b0, seq_q} < space_eff) && (offset < {1'b0, win_eff});
    status.at_base   = (offset == '0);
    status.run_more  = (run_cnt < win_eff) && held_mark[cursor];
    status.out_free  = !out_valid || out_ready;
  end

  // Track window base, delivery cursor and marks
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      window_base <= '0;
      held_mark   <= '0;
    end else begin
      if (cmd.store) held_mark[seq_q] <= 1'b1;
      if (cmd.load_data) held_mark[cursor] <= 1'b0;
      if (cmd.end_run) window_base <= cursor;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_head) begin
      cursor  <= head_next;
      run_cnt <= srr_pkg::WIN_W'(1);
    end else if (cmd.load_data) begin
      cursor  <= cursor_next;
      run_cnt <= run_cnt + srr_pkg::WIN_W'(1);
    end
  end

  // Held payload memory with registered read
  always_ff @(posedge clk) begin
    if (cmd.store) held_payload[seq_q] <= payload_q;
    rd_data <= held_payload[cursor];
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_any) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    priority if (cmd.load_head) begin
      kind     <= srr_pkg::KIND_DATA;
      ack_num  <= '0;
      data_out <= payload_q;
      last     <= 1'b0;
    end else if (cmd.load_data) begin
      kind     <= srr_pkg::KIND_DATA;
      ack_num  <= '0;
      data_out <= rd_data;
      last     <= 1'b0;
    end else if (cmd.load_ack) begin
      kind     <= srr_pkg::KIND_ACK;
      ack_num  <= seq_q;
      data_out <= '0;
      last     <= 1'b1;
    end
  end

`ifndef SYNTHESIS
  a_one_load: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load_head, cmd.load_data, cmd.load_ack}))
    else $error("more than one result loaded in a cycle");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    load_any |-> (!out_valid || out_ready))
    else $error("result register overwritten while held");

  a_base_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, window_base} < space_eff)
    else $error("window base outside sequence space");

  a_base_unmarked: assert property (@(posedge clk) disable iff (rst || restart)
    cmd.end_run |=> !held_mark[window_base])
    else $error("new window base still marked");
`endif

endmodule

// ===== rtl/selective_repeat_receiver.sv =====
// A corrupt packet returns to idle after the check state; an out-of-window or held
// packet goes on to the ack state, which loads its result once the output is free;
// an in-order packet passes head, read, a send and read per released held entry,
// and ack, one memory entry at a time. New packets are accepted only in idle.
// Reset: window base 0, all marks cleared, seq_space 8, window_size 4, no result
// pending; the held-payload memory is not cleared.
module selective_repeat_receiver (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [srr_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [srr_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [srr_pkg::SEQ_W-1:0]      seq_num,
  input  logic                           checksum_ok,
  input  logic [srr_pkg::DATA_W-1:0]     payload,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           kind,
  output logic [srr_pkg::SEQ_W-1:0]      ack_num,
  output logic [srr_pkg::DATA_W-1:0]     data_out,
  output logic                           last
);

  srr_pkg::srr_cmd_t    cmd;
  srr_pkg::srr_status_t status;

  // Sequence the work for each request
  srr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Hold window state and results
  srr_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .seq_num     (seq_num),
    .checksum_ok (checksum_ok),
    .payload     (payload),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .kind        (kind),
    .ack_num     (ack_num),
    .data_out    (data_out),
    .last        (last),
    .cmd         (cmd),
    .status      (status)
  );

endmodule

// ===== test/tb_selective_repeat_receiver.sv =====
// Self-checking testbench for the selective-repeat ARQ receiver.
module tb_selective_repeat_receiver;
  timeunit 1ns;
  timeprecision 1ps;

  // Indexes that name no register; writes to them must change nothing
  localparam logic [srr_pkg::CFG_ADDR_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [srr_pkg::CFG_ADDR_W-1:0] REG_SPARE_B = 2'd3;

  localparam int MAX_GAP     = 12;
  localparam int SETTLE      = 10;
  localparam int STALL_LIMIT = 4000;
  localparam int PHASE_ITEMS = 40;

  typedef struct packed {
    logic                       kind;
    logic [srr_pkg::SEQ_W-1:0]  ack;
    logic [srr_pkg::DATA_W-1:0] data;
    logic                       last;
  } arq_result_t;

  logic                           clk;
  logic                           rst;
  logic                           cfg_we;
  logic [srr_pkg::CFG_ADDR_W-1:0] cfg_addr;
  logic [srr_pkg::CFG_DATA_W-1:0] cfg_wdata;
  logic                           in_valid;
  logic                           in_ready;
  logic [srr_pkg::SEQ_W-1:0]      seq_num;
  logic                           checksum_ok;
  logic [srr_pkg::DATA_W-1:0]     payload;
  logic                           out_valid;
  logic                           out_ready;
  logic                           kind;
  logic [srr_pkg::SEQ_W-1:0]      ack_num;
  logic [srr_pkg::DATA_W-1:0]     data_out;
  logic                           last;

  // Receiver mirror: configuration, window base, marks and held payloads
  logic [srr_pkg::SPACE_W-1:0] rx_space;
  logic [srr_pkg::WIN_W-1:0]   rx_window;
  int                          rx_base;
  bit                          rx_marked [srr_pkg::MAX_SEQ];
  logic [srr_pkg::DATA_W-1:0]  rx_held   [srr_pkg::MAX_SEQ];

  arq_result_t emit_q[$];

  bit sender_idles;
  bit receiver_idles;
  int mismatches;
  int packets_sent;
  int corrupt_sent;
  int deliveries_seen;
  int acks_seen;
  int reg_writes;

  selective_repeat_receiver uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .seq_num    (seq_num),
    .checksum_ok(checksum_ok),
    .payload    (payload),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .kind       (kind),
    .ack_num    (ack_num),
    .data_out   (data_out),
    .last       (last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Effective sequence space after clamping
  function automatic int space_now();
    if (rx_space < srr_pkg::SPACE_MIN) return int'(srr_pkg::SPACE_MIN);
    if (rx_space > srr_pkg::SPACE_MAX) return int'(srr_pkg::SPACE_MAX);
    return int'(rx_space);
  endfunction

  // Effective window, limited by the space and the hard cap
  function automatic int window_now(input int sp);
    int w;
    w = int'(rx_window);
    if (w < 1) w = 1;
    if (w > sp) w = sp;
    if (w > int'(srr_pkg::WIN_LIMIT)) w = int'(srr_pkg::WIN_LIMIT);
    return w;
  endfunction

  function automatic void restart_window();
    rx_base = 0;
    foreach (rx_marked[i]) rx_marked[i] = 1'b0;
  endfunction

  function automatic void push_result(input logic k, input int a,
                                      input logic [srr_pkg::DATA_W-1:0] d, input logic l);
    arq_result_t r;
    r.kind = k;
    r.ack  = a[srr_pkg::SEQ_W-1:0];
    r.data = d;
    r.last = l;
    emit_q.push_back(r);
  endfunction

  // Work out the acknowledgements and deliveries one accepted packet causes
  function automatic void absorb_packet(input logic [srr_pkg::SEQ_W-1:0] seq, input logic ok,
                                        input logic [srr_pkg::DATA_W-1:0] data);
    int sq;
    int sp;
    int w;
    int base;
    int off;
    int run;
    int idx;
    if (!ok) return;
    sq   = int'(seq);
    sp   = space_now();
    w    = window_now(sp);
    base = rx_base % sp;
    if (sq >= sp) begin
      push_result(srr_pkg::KIND_ACK, sq, '0, 1'b1);
      return;
    end
    off = (sq + sp - base) % sp;
    if (off >= w) begin
      push_result(srr_pkg::KIND_ACK, sq, '0, 1'b1);
      return;
    end
    if (off == 0) begin
      // deliver the head, then the consecutive held run behind it
      push_result(srr_pkg::KIND_DATA, 0, data, 1'b0);
      run = 0;
      for (int j = 1; j < w; j++) begin
        idx = (base + j) % sp;
        if (!rx_marked[idx]) break;
        run = j;
      end
      for (int j = 1; j <= run; j++) begin
        idx = (base + j) % sp;
        push_result(srr_pkg::KIND_DATA, 0, rx_held[idx], 1'b0);
        rx_marked[idx] = 1'b0;
      end
      rx_base = (base + run + 1) % sp;
    end else begin
      rx_held[sq]   = data;
      rx_marked[sq] = 1'b1;
    end
    push_result(srr_pkg::KIND_ACK, sq, '0, 1'b1);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // Offer one packet, hold it until accepted, then predict its results
  task automatic send_packet(input logic [srr_pkg::SEQ_W-1:0] seq, input logic ok,
                             input logic [srr_pkg::DATA_W-1:0] data);
    int gap;
    gap = sender_idles ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    seq_num     <= seq;
    checksum_ok <= ok;
    payload     <= data;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    packets_sent++;
    if (!ok) corrupt_sent++;
    absorb_packet(seq, ok, data);
  endtask

  // Drop valid, wait for every predicted result, then let the block settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (emit_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [srr_pkg::CFG_ADDR_W-1:0] addr,
                           input logic [srr_pkg::CFG_DATA_W-1:0] value);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    reg_writes++;
    if (addr == srr_pkg::REG_SEQ_SPACE) begin
      rx_space = value;
      restart_window();
    end else if (addr == srr_pkg::REG_WINDOW_SIZE) begin
      rx_window = value[srr_pkg::WIN_W-1:0];
      restart_window();
    end
    @(posedge clk);
  endtask

  // Default window after reset: corrupt, wrap, held run, duplicate, extremes
  task automatic test_default_window();
    send_packet(4'd0, 1'b0, 32'h1234_5678);
    send_packet(4'd0, 1'b1, 32'h0000_0000);
    send_packet(4'd15, 1'b1, 32'hFFFF_FFFF);
    send_packet(4'd6, 1'b1, 32'hA5A5_A5A5);
    send_packet(4'd3, 1'b1, 32'h0000_0003);
    send_packet(4'd3, 1'b1, 32'h3333_3333);
    send_packet(4'd2, 1'b1, 32'h2222_2222);
    send_packet(4'd4, 1'b1, 32'h4444_4444);
    send_packet(4'd1, 1'b1, 32'hFFFF_FFFF);
    send_packet(4'd7, 1'b1, 32'h7777_7777);
    send_packet(4'd5, 1'b1, 32'h5555_5555);
    send_packet(4'd6, 1'b1, 32'h6666_6666);
  endtask

  // Oversized space and window clamp to the widest setting; release a full run
  task automatic test_wide_window();
    write_reg(srr_pkg::REG_SEQ_SPACE, 5'd31);
    write_reg(srr_pkg::REG_WINDOW_SIZE, 5'd15);
    for (int s = 1; s < 8; s++) send_packet(s[srr_pkg::SEQ_W-1:0], 1'b1, $urandom);
    send_packet(4'd0, 1'b1, $urandom);
  endtask

  // Undersized settings clamp to the narrowest; spare indexes change nothing
  task automatic test_narrow_window();
    write_reg(srr_pkg::REG_SEQ_SPACE, 5'd0);
    write_reg(srr_pkg::REG_WINDOW_SIZE, 5'd0);
    send_packet(4'd1, 1'b1, $urandom);
    send_packet(4'd0, 1'b1, $urandom);
    write_reg(srr_pkg::REG_WINDOW_SIZE, 5'd5);
    send_packet(4'd1, 1'b1, $urandom);
    write_reg(REG_SPARE_A, 5'd31);
    write_reg(REG_SPARE_B, 5'd1);
    send_packet(4'd0, 1'b1, $urandom);
  endtask

  // Mostly in-window traffic with random content, plus noise and corrupt packets
  task automatic run_phase(input logic [srr_pkg::CFG_DATA_W-1:0] space_val,
                           input logic [srr_pkg::CFG_DATA_W-1:0] win_val,
                           input bit pause_midway);
    int counted;
    int sp;
    int w;
    int pick;
    logic [srr_pkg::SEQ_W-1:0] seq;
    logic ok;
    write_reg(srr_pkg::REG_SEQ_SPACE, space_val);
    write_reg(srr_pkg::REG_WINDOW_SIZE, win_val);
    counted = 0;
    while (counted < PHASE_ITEMS) begin
      sp   = space_now();
      w    = window_now(sp);
      pick = $urandom_range(0, 99);
      ok   = 1'b1;
      if (pick < 10) begin
        ok  = 1'b0;
        seq = srr_pkg::SEQ_W'($urandom_range(0, 15));
      end else if (pick < 22) begin
        seq = srr_pkg::SEQ_W'($urandom_range(0, 15));
      end else if (pick < 40 || w == 1) begin
        seq = srr_pkg::SEQ_W'(rx_base % sp);
      end else begin
        seq = srr_pkg::SEQ_W'((rx_base + $urandom_range(1, w - 1)) % sp);
      end
      send_packet(seq, ok, $urandom);
      if (ok) counted++;
      if (pause_midway && counted == PHASE_ITEMS / 2) wait_idle();
    end
  endtask

  task automatic test_random_traffic();
    sender_idles   = 1'b1;
    receiver_idles = 1'b1;
    run_phase(5'd16, 5'd8, 1'b0);
    sender_idles   = 1'b0;
    receiver_idles = 1'b0;
    run_phase(5'd2, 5'd1, 1'b0);
    for (int p = 0; p < 3; p++) begin
      sender_idles   = 1'($urandom_range(0, 1));
      receiver_idles = 1'($urandom_range(0, 1));
      run_phase(srr_pkg::CFG_DATA_W'($urandom_range(0, 31)),
                srr_pkg::CFG_DATA_W'($urandom_range(0, 31)), p == 0);
    end
  endtask

  // Result side: draw a stall for each result, hold ready until it is taken
  initial begin
    int gap;
    out_ready <= 1'b0;
    @(posedge clk);
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      gap = receiver_idles ? $urandom_range(0, MAX_GAP) : 0;
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!(out_valid === 1'b1 && out_ready === 1'b1)) @(posedge clk);
    end
  end

  // Compare each taken result with the oldest prediction
  always @(posedge clk) begin
    arq_result_t want;
    if (rst === 1'b0 && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (emit_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0b ack %0d data %h last %0b",
                                  kind, ack_num, data_out, last));
      end else begin
        want = emit_q.pop_front();
        if (kind !== want.kind)
          report_mismatch($sformatf("kind %0b, want %0b", kind, want.kind));
        if (ack_num !== want.ack)
          report_mismatch($sformatf("ack_num %0d, want %0d", ack_num, want.ack));
        if (data_out !== want.data)
          report_mismatch($sformatf("data_out %h, want %h", data_out, want.data));
        if (last !== want.last)
          report_mismatch($sformatf("last %0b, want %0b", last, want.last));
      end
      if (kind === srr_pkg::KIND_DATA) deliveries_seen++;
      else acks_seen++;
    end
  end

  // Give up when nothing moves on either channel for too long
  initial begin
    int idle_run;
    idle_run = 0;
    while (idle_run < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid === 1'b1 && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready === 1'b1))
        idle_run = 0;
      else
        idle_run++;
    end
    $display("timeout: no request or result moved for %0d cycles, %0d results outstanding",
             STALL_LIMIT, emit_q.size());
    $display("selective_repeat_receiver verification failed");
    $finish;
  end

  initial begin
    rst         <= 1'b1;
    cfg_we      <= 1'b0;
    cfg_addr    <= '0;
    cfg_wdata   <= '0;
    in_valid    <= 1'b0;
    seq_num     <= '0;
    checksum_ok <= 1'b0;
    payload     <= '0;
    rx_space    = srr_pkg::SPACE_RESET;
    rx_window   = srr_pkg::WIN_RESET;
    restart_window();
    foreach (rx_held[i]) rx_held[i] = '0;
    sender_idles   = 1'b1;
    receiver_idles = 1'b1;
    mismatches      = 0;
    packets_sent    = 0;
    corrupt_sent    = 0;
    deliveries_seen = 0;
    acks_seen       = 0;
    reg_writes      = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_default_window();
    test_wide_window();
    test_narrow_window();
    test_random_traffic();

    // Drain, then watch a while longer for stray results
    wait_idle();
    repeat (40) @(posedge clk);

    $display("covered %0d packets (%0d corrupt) under %0d register writes",
             packets_sent, corrupt_sent, reg_writes);
    $display("checked %0d deliveries and %0d acknowledgements, %0d mismatches",
             deliveries_seen, acks_seen, mismatches);
    if (mismatches == 0 && emit_q.size() == 0) begin
      $display("selective_repeat_receiver verification clean");
    end else begin
      $display("selective_repeat_receiver verification failed");
    end
    $finish;
  end

endmodule
